// ===== sv/odo_pkg.sv =====
package odo_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STAGES   = 32;
  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES  = 4;
  localparam int LATENCY      = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  localparam logic [31:0]        PI_Q30     = 32'd3373259426;
  localparam logic [32:0]        TWOPI_Q30  = 33'd6746518852;
  localparam logic [29:0]        INV2PI_Q32 = 30'd683565276;
  localparam logic signed [33:0] GAIN_Q30   = 34'sd652032874;

  localparam logic [31:0] RADIUS_RESET = 32'd6554;
  localparam logic [31:0] BASE_RESET   = 32'd65536;
  localparam logic [15:0] TICKS_RESET  = 16'd16;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_BASE   = 2'd1,
    REG_TICKS  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] hd;
    logic               sum_neg;
    logic               diff_neg;
    logic [1:0]         quad;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [32:0] cz;
    logic [63:0]        dc_q;
    logic [47:0]        dc_r;
    logic [47:0]        dc_v;
    logic [63:0]        dh_q;
    logic [47:0]        dh_r;
    logic [47:0]        dh_v;
  } iter_t;

  function automatic logic signed [32:0] atan_q30(input int unsigned i);
    case (i)
      0:       return 33'sd843314856;
      1:       return 33'sd497837829;
      2:       return 33'sd263043836;
      3:       return 33'sd133525158;
      4:       return 33'sd67021686;
      5:       return 33'sd33543515;
      6:       return 33'sd16775850;
      7:       return 33'sd8388437;
      8:       return 33'sd4194282;
      9:       return 33'sd2097149;
      10:      return 33'sd1048575;
      11:      return 33'sd524287;
      12:      return 33'sd262143;
      13:      return 33'sd131071;
      14:      return 33'sd65535;
      15:      return 33'sd32767;
      16:      return 33'sd16383;
      17:      return 33'sd8191;
      18:      return 33'sd4095;
      19:      return 33'sd2047;
      20:      return 33'sd1023;
      21:      return 33'sd511;
      22:      return 33'sd255;
      23:      return 33'sd127;
      default: return 33'sd0;
    endcase
  endfunction

endpackage

// ===== sv/odo_iter.sv =====
module odo_iter (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  odo_pkg::iter_t in_item,
  output logic          out_valid,
  output odo_pkg::iter_t out_item
);

  odo_pkg::iter_t stage [odo_pkg::DIV_STAGES+1];
  logic           valid [odo_pkg::DIV_STAGES+1];

  // Two quotient bits of each division a stage, and one rotation while steps remain.
  function automatic odo_pkg::iter_t step(input odo_pkg::iter_t a, input int unsigned k);
    odo_pkg::iter_t     b;
    logic [48:0]        t;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    b = a;
    for (int j = 0; j < 2; j++) begin
      t = {b.dc_r, b.dc_q[63]};
      if (t >= {1'b0, b.dc_v}) begin
        b.dc_r = 48'(t - {1'b0, b.dc_v});
        b.dc_q = {b.dc_q[62:0], 1'b1};
      end else begin
        b.dc_r = t[47:0];
        b.dc_q = {b.dc_q[62:0], 1'b0};
      end
      t = {b.dh_r, b.dh_q[63]};
      if (t >= {1'b0, b.dh_v}) begin
        b.dh_r = 48'(t - {1'b0, b.dh_v});
        b.dh_q = {b.dh_q[62:0], 1'b1};
      end else begin
        b.dh_r = t[47:0];
        b.dh_q = {b.dh_q[62:0], 1'b0};
      end
    end
    if (k < odo_pkg::CORDIC_STEPS) begin
      xs = a.cx >>> k;
      ys = a.cy >>> k;
      if (!a.cz[32]) begin
        b.cx = a.cx - ys;
        b.cy = a.cy + xs;
        b.cz = a.cz - odo_pkg::atan_q30(k);
      end else begin
        b.cx = a.cx + ys;
        b.cy = a.cy - xs;
        b.cz = a.cz + odo_pkg::atan_q30(k);
      end
    end
    return b;
  endfunction

  assign stage[0] = in_item;
  assign valid[0] = in_valid;

  for (genvar g = 0; g < odo_pkg::DIV_STAGES; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[g+1] <= 1'b0;
      end else begin
        valid[g+1] <= valid[g];
      end
      stage[g+1] <= step(stage[g], g);
    end
  end

  assign out_valid = valid[odo_pkg::DIV_STAGES];
  assign out_item  = stage[odo_pkg::DIV_STAGES];

endmodule

// ===== sv/diff_drive_odometry_update_top.sv =====
// Differential-drive odometry update.
// An item (prior pose and the two wheel tick counts) is taken at a rising
// edge where start is high and busy is low. Busy is high only during reset,
// so a new item may be given in every cycle.
// The updated pose appears on new_x, new_y, new_heading and saturated for
// one cycle, marked by result_valid.
// The pipeline has four set-up stages (radius product, phase, wheel distance
// products, dividends), 32 stages of the two long divisions, which resolve
// two quotient bits a stage and carry the CORDIC rotations alongside, and
// four stages of scaling and saturation. Throughput is one item a cycle.
// The receiver cannot hold results off, so none is needed: every item
// leaves exactly once in order. Reset empties the pipeline, drops items in
// flight and loads the default radius, wheel base and ticks per turn.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must write them while no
// item is in flight, which the block itself does not enforce; an unknown index is ignored.
module diff_drive_odometry_update_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] heading,
  input  logic signed [15:0] left_ticks,
  input  logic signed [15:0] right_ticks,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               result_valid,
  output logic signed [31:0] new_x,
  output logic signed [31:0] new_y,
  output logic signed [31:0] new_heading,
  output logic               saturated
);

  localparam logic signed [63:0] SMAX = 64'sd2147483647;
  localparam logic signed [63:0] SMIN = -64'sd2147483648;

  function automatic logic [32:0] clip32(input logic signed [63:0] v);
    if (v > SMAX) begin
      return {1'b1, 32'h7fffffff};
    end else if (v < SMIN) begin
      return {1'b1, 32'h80000000};
    end
    return {1'b0, v[31:0]};
  endfunction

  logic [31:0] wheel_radius;
  logic [31:0] wheel_base;
  logic [15:0] ticks_per_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_radius   <= odo_pkg::RADIUS_RESET;
      wheel_base     <= odo_pkg::BASE_RESET;
      ticks_per_turn <= odo_pkg::TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        odo_pkg::REG_RADIUS: wheel_radius   <= cfg_data;
        odo_pkg::REG_BASE:   wheel_base     <= cfg_data;
        odo_pkg::REG_TICKS:  ticks_per_turn <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign busy = rst;

  logic               accept;
  logic [15:0]        nz;
  logic [31:0]        bz;
  logic signed [16:0] sum_w;
  logic signed [16:0] diff_w;
  logic signed [62:0] head_prod;

  assign accept    = start && !busy;
  assign nz        = (ticks_per_turn == 16'd0) ? 16'd1 : ticks_per_turn;
  assign bz        = (wheel_base == 32'd0) ? 32'd1 : wheel_base;
  assign sum_w     = 17'(left_ticks) + 17'(right_ticks);
  assign diff_w    = 17'(right_ticks) - 17'(left_ticks);
  assign head_prod = 63'(heading) * 63'($signed({1'b0, odo_pkg::INV2PI_Q32}));

  // Stage F1.
  logic               f1_valid;
  logic signed [31:0] f1_px, f1_py, f1_hd;
  logic               f1_sneg, f1_dneg;
  logic [16:0]        f1_ms, f1_md;
  logic [63:0]        f1_prraw;
  logic [31:0]        f1_phase;
  logic [47:0]        f1_nb, f1_dcv;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= accept;
    end
    f1_px    <= pos_x;
    f1_py    <= pos_y;
    f1_hd    <= heading;
    f1_sneg  <= sum_w[16];
    f1_dneg  <= diff_w[16];
    f1_ms    <= sum_w[16] ? 17'(-sum_w) : 17'(sum_w);
    f1_md    <= diff_w[16] ? 17'(-diff_w) : 17'(diff_w);
    f1_prraw <= 64'(wheel_radius) * 64'(odo_pkg::PI_Q30);
    f1_phase <= head_prod[47:16];
    f1_nb    <= 48'(nz) * 48'(bz);
    f1_dcv   <= {16'd0, nz, 16'd0};
  end

  // Stage F2.
  logic               f2_valid;
  logic signed [31:0] f2_px, f2_py, f2_hd;
  logic               f2_sneg, f2_dneg;
  logic [16:0]        f2_ms, f2_md;
  logic [49:0]        f2_pr;
  logic [1:0]         f2_quad;
  logic [30:0]        f2_z;
  logic [47:0]        f2_nb, f2_dcv;
  logic [62:0]        z_prod;

  assign z_prod = 63'(f1_phase[29:0]) * 63'(odo_pkg::TWOPI_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else begin
      f2_valid <= f1_valid;
    end
    f2_px   <= f1_px;
    f2_py   <= f1_py;
    f2_hd   <= f1_hd;
    f2_sneg <= f1_sneg;
    f2_dneg <= f1_dneg;
    f2_ms   <= f1_ms;
    f2_md   <= f1_md;
    f2_pr   <= 50'((f1_prraw + 64'd8192) >> 14);
    f2_quad <= f1_phase[31:30];
    f2_z    <= z_prod[62:32];
    f2_nb   <= f1_nb;
    f2_dcv  <= f1_dcv;
  end

  // Stage F3.
  logic               f3_valid;
  logic signed [31:0] f3_px, f3_py, f3_hd;
  logic               f3_sneg, f3_dneg;
  logic [1:0]         f3_quad;
  logic [30:0]        f3_z;
  logic [47:0]        f3_nb, f3_dcv;
  logic [48:0]        f3_pls, f3_pld;
  logic [34:0]        f3_phs, f3_phd;

  always_ff @(posedge clk) begin
    if (rst) begin
      f3_valid <= 1'b0;
    end else begin
      f3_valid <= f2_valid;
    end
    f3_px   <= f2_px;
    f3_py   <= f2_py;
    f3_hd   <= f2_hd;
    f3_sneg <= f2_sneg;
    f3_dneg <= f2_dneg;
    f3_quad <= f2_quad;
    f3_z    <= f2_z;
    f3_nb   <= f2_nb;
    f3_dcv  <= f2_dcv;
    f3_pls  <= 49'(f2_pr[31:0]) * 49'(f2_ms);
    f3_phs  <= 35'(f2_pr[49:32]) * 35'(f2_ms);
    f3_pld  <= 49'(f2_pr[31:0]) * 49'(f2_md);
    f3_phd  <= 35'(f2_pr[49:32]) * 35'(f2_md);
  end

  // Stage F4: dividends wrap to 64 bits.
  logic           f4_valid;
  odo_pkg::iter_t f4_item;
  logic [63:0]    prod_s, prod_d;

  assign prod_s = 64'(f3_pls) + {f3_phs[31:0], 32'd0};
  assign prod_d = 64'(f3_pld) + {f3_phd[31:0], 32'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      f4_valid <= 1'b0;
    end else begin
      f4_valid <= f3_valid;
    end
    f4_item.px       <= f3_px;
    f4_item.py       <= f3_py;
    f4_item.hd       <= f3_hd;
    f4_item.sum_neg  <= f3_sneg;
    f4_item.diff_neg <= f3_dneg;
    f4_item.quad     <= f3_quad;
    f4_item.cx       <= odo_pkg::GAIN_Q30;
    f4_item.cy       <= 34'sd0;
    f4_item.cz       <= $signed({2'b00, f3_z});
    f4_item.dc_q     <= prod_s + 64'(f3_dcv >> 1);
    f4_item.dc_r     <= 48'd0;
    f4_item.dc_v     <= f3_dcv;
    f4_item.dh_q     <= {prod_d[62:0], 1'b0} + 64'(f3_nb >> 1);
    f4_item.dh_r     <= 48'd0;
    f4_item.dh_v     <= f3_nb;
  end

  logic           it_valid;
  odo_pkg::iter_t it_item;

  odo_iter u_iter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f4_valid),
    .in_item   (f4_item),
    .out_valid (it_valid),
    .out_item  (it_item)
  );

  // Stage B1: quadrant, heading sum.
  logic signed [33:0] rc, rs;
  logic signed [33:0] rc_abs, rs_abs;
  logic [63:0]        dh64;
  logic signed [63:0] nh64;

  always_comb begin
    case (it_item.quad)
      2'd0:    begin rc = it_item.cx;  rs = it_item.cy;  end
      2'd1:    begin rc = -it_item.cy; rs = it_item.cx;  end
      2'd2:    begin rc = -it_item.cx; rs = -it_item.cy; end
      default: begin rc = it_item.cy;  rs = -it_item.cx; end
    endcase
    rc_abs = rc[33] ? -rc : rc;
    rs_abs = rs[33] ? -rs : rs;
    dh64   = it_item.diff_neg ? -it_item.dh_q : it_item.dh_q;
    nh64   = 64'(it_item.hd) + $signed(dh64);
  end

  logic               b1_valid;
  logic signed [31:0] b1_px, b1_py;
  logic [32:0]        b1_nh;
  logic [47:0]        b1_dcm;
  logic [31:0]        b1_cm, b1_sm;
  logic               b1_cneg, b1_sneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= it_valid;
    end
    b1_px   <= it_item.px;
    b1_py   <= it_item.py;
    b1_nh   <= clip32(nh64);
    b1_dcm  <= it_item.dc_q[47:0];
    b1_cm   <= rc_abs[31:0];
    b1_sm   <= rs_abs[31:0];
    b1_cneg <= it_item.sum_neg ^ rc[33];
    b1_sneg <= it_item.sum_neg ^ rs[33];
  end

  // Stage B2: partial products.
  logic               b2_valid;
  logic signed [31:0] b2_px, b2_py;
  logic [32:0]        b2_nh;
  logic               b2_cneg, b2_sneg;
  logic [63:0]        b2_cl, b2_sl;
  logic [47:0]        b2_ch, b2_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      b2_valid <= 1'b0;
    end else begin
      b2_valid <= b1_valid;
    end
    b2_px   <= b1_px;
    b2_py   <= b1_py;
    b2_nh   <= b1_nh;
    b2_cneg <= b1_cneg;
    b2_sneg <= b1_sneg;
    b2_cl   <= 64'(b1_dcm[31:0]) * 64'(b1_cm);
    b2_sl   <= 64'(b1_dcm[31:0]) * 64'(b1_sm);
    b2_ch   <= 48'(b1_dcm[47:32]) * 48'(b1_cm);
    b2_sh   <= 48'(b1_dcm[47:32]) * 48'(b1_sm);
  end

  // Stage B3: rounding and sign.
  logic [63:0] mc, ms;

  assign mc = {14'd0, b2_ch, 2'b00} + ((b2_cl + 64'h20000000) >> 30);
  assign ms = {14'd0, b2_sh, 2'b00} + ((b2_sl + 64'h20000000) >> 30);

  logic               b3_valid;
  logic signed [31:0] b3_px, b3_py;
  logic [32:0]        b3_nh;
  logic signed [63:0] b3_mx, b3_my;

  always_ff @(posedge clk) begin
    if (rst) begin
      b3_valid <= 1'b0;
    end else begin
      b3_valid <= b2_valid;
    end
    b3_px <= b2_px;
    b3_py <= b2_py;
    b3_nh <= b2_nh;
    b3_mx <= b2_cneg ? -$signed(mc) : $signed(mc);
    b3_my <= b2_sneg ? -$signed(ms) : $signed(ms);
  end

  // Stage B4: position sums, saturation, result register.
  logic [32:0] cx_res, cy_res;

  assign cx_res = clip32(64'(b3_px) + b3_mx);
  assign cy_res = clip32(64'(b3_py) + b3_my);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= b3_valid;
    end
    new_x       <= cx_res[31:0];
    new_y       <= cy_res[31:0];
    new_heading <= b3_nh[31:0];
    saturated   <= cx_res[32] | cy_res[32] | b3_nh[32];
  end

  a_result_from_item: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(accept, odo_pkg::LATENCY))
    else $error("result without an accepted item");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    (result_valid && saturated) |->
      (new_x == 32'sh7fffffff || new_x == 32'sh80000000 ||
       new_y == 32'sh7fffffff || new_y == 32'sh80000000 ||
       new_heading == 32'sh7fffffff || new_heading == 32'sh80000000))
    else $error("saturation flagged with no clipped value");

  a_still_wheels: assert property (@(posedge clk) disable iff (rst)
    (accept && left_ticks == 16'sd0 && right_ticks == 16'sd0) |->
      ##40 (!result_valid ||
            (new_heading == $past(heading, odo_pkg::LATENCY) &&
             new_x == $past(pos_x, odo_pkg::LATENCY) &&
             new_y == $past(pos_y, odo_pkg::LATENCY) && !saturated)))
    else $error("pose moved with no wheel ticks");

endmodule
